// ===== sv/slps_pkg.sv =====
// shared constants for the speed limited point step block
package slps_pkg;

  localparam int unsigned SpeedWidth = 24;
  localparam int unsigned DtWidth    = 16;
  localparam int unsigned LimitWidth = 21;
  localparam logic [19:0] UsPerS     = 20'd1000000;

endpackage

// ===== sv/slps_if.sv =====
// valid/ready channel carrying one point step item or result
interface slps_if #(
  parameter int unsigned W = 24
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] cur_x;
  logic signed [W-1:0] cur_y;
  logic signed [W-1:0] cur_z;
  logic signed [W-1:0] goal_x;
  logic signed [W-1:0] goal_y;
  logic signed [W-1:0] goal_z;
  logic [15:0]         dt_us;
  logic signed [W-1:0] new_x;
  logic signed [W-1:0] new_y;
  logic signed [W-1:0] new_z;
  logic                limited;

  modport source (output valid, cur_x, cur_y, cur_z, goal_x, goal_y, goal_z, dt_us,
                  new_x, new_y, new_z, limited, input ready);
  modport sink   (input valid, cur_x, cur_y, cur_z, goal_x, goal_y, goal_z, dt_us,
                  new_x, new_y, new_z, limited, output ready);
endinterface

// ===== sv/slps_sqrt.sv =====
// pipelined integer square root, one result bit per stage
module slps_sqrt #(
  parameter int unsigned RW = 35,
  parameter int unsigned TW = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [2*RW-1:0]   rad_i,
  input  logic [TW-1:0]     tag_i,
  output logic              valid_o,
  output logic [RW-1:0]     root_o,
  output logic [TW-1:0]     tag_o
);
  // per stage: remainder, partial root, leftover radicand bits
  logic [RW:0]     valid_q;
  logic [RW+1:0]   rem_q  [RW+1];
  logic [RW-1:0]   root_q [RW+1];
  logic [2*RW-1:0] rad_q  [RW+1];
  logic [TW-1:0]   tag_q  [RW+1];

  always_comb begin
    valid_q[0] = valid_i;
    rem_q[0]   = '0;
    root_q[0]  = '0;
    rad_q[0]   = rad_i;
    tag_q[0]   = tag_i;
  end

  for (genvar s = 0; s < RW; s++) begin : g_stage
    logic [RW+1:0] rem_sh, trial;
    always_comb begin
      rem_sh = {rem_q[s][RW-1:0], rad_q[s][2*RW-1 -: 2]};
      trial  = {root_q[s], 2'b01};
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s+1] <= 1'b0;
      end else if (en_i) begin
        valid_q[s+1] <= valid_q[s];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[s+1] <= {rad_q[s][2*RW-3:0], 2'b00};
        tag_q[s+1] <= tag_q[s];
        if (rem_sh >= trial) begin
          rem_q[s+1]  <= rem_sh - trial;
          root_q[s+1] <= {root_q[s][RW-2:0], 1'b1};
        end else begin
          rem_q[s+1]  <= rem_sh;
          root_q[s+1] <= {root_q[s][RW-2:0], 1'b0};
        end
      end
    end
  end

  assign valid_o = valid_q[RW];
  assign root_o  = root_q[RW];
  assign tag_o   = tag_q[RW];
endmodule

// ===== sv/slps_div.sv =====
// pipelined restoring divider, one quotient bit per stage
module slps_div #(
  parameter int unsigned NW = 48,
  parameter int unsigned DW = 35,
  parameter int unsigned TW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [TW-1:0] tag_i,
  output logic          valid_o,
  output logic [NW-1:0] quo_o,
  output logic [TW-1:0] tag_o
);
  logic [NW:0]   valid_q;
  logic [DW:0]   rem_q [NW+1];
  logic [NW-1:0] num_q [NW+1];
  logic [DW-1:0] den_q [NW+1];
  logic [TW-1:0] tag_q [NW+1];

  always_comb begin
    valid_q[0] = valid_i;
    rem_q[0]   = '0;
    num_q[0]   = num_i;
    den_q[0]   = den_i;
    tag_q[0]   = tag_i;
  end

  for (genvar s = 0; s < NW; s++) begin : g_stage
    logic [DW:0] rsh;
    assign rsh = {rem_q[s][DW-1:0], num_q[s][NW-1]};
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s+1] <= 1'b0;
      end else if (en_i) begin
        valid_q[s+1] <= valid_q[s];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[s+1] <= den_q[s];
        tag_q[s+1] <= tag_q[s];
        if (rsh >= {1'b0, den_q[s]}) begin
          rem_q[s+1] <= rsh - {1'b0, den_q[s]};
          num_q[s+1] <= {num_q[s][NW-2:0], 1'b1};
        end else begin
          rem_q[s+1] <= rsh;
          num_q[s+1] <= {num_q[s][NW-2:0], 1'b0};
        end
      end
    end
  end

  assign valid_o = valid_q[NW];
  assign quo_o   = num_q[NW];
  assign tag_o   = tag_q[NW];
endmodule

// ===== sv/speed_limited_point_step.sv =====
// throughput: one item per cycle unless stalled; the square root and divider pipelines set the latency
// a full output register that is not taken stalls every stage together, nothing is lost or repeated
// reset clears all valid bits and sets max_speed to 0
module speed_limited_point_step #(
  parameter int unsigned COORD_WIDTH = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [slps_pkg::SpeedWidth-1:0] cfg_wdata_i,
  slps_if.sink                          in_if,
  slps_if.source                        out_if
);
  import slps_pkg::*;

  localparam int unsigned W   = COORD_WIDTH;
  localparam int unsigned MW  = W + 1;          // axis difference magnitude
  localparam int unsigned SW  = 2 * MW + 2;     // sum of three squares
  localparam int unsigned RW  = SW / 2;         // root width
  localparam int unsigned NW  = MW + LimitWidth; // mag * limit
  localparam int unsigned TW  = 3 * MW + 3 * W + 3 + LimitWidth;
  localparam int unsigned PW  = SpeedWidth + DtWidth;

  logic [SpeedWidth-1:0] max_speed_q;
  logic en;

  // whole pipeline advances unless a held result is not taken
  assign en = !out_if.valid || out_if.ready;
  assign in_if.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_speed_q <= '0;
    end else if (cfg_we_i) begin
      max_speed_q <= cfg_wdata_i;
    end
  end

  // stage 1: differences and speed product
  logic              v1_q;
  logic signed [W:0] d1_q [3];
  logic [W-1:0]      c1_q [3];
  logic [W-1:0]      g1_q [3];
  logic [PW-1:0]     p1_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (en) v1_q <= in_if.valid;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      d1_q[0] <= $signed({in_if.goal_x[W-1], in_if.goal_x}) - $signed({in_if.cur_x[W-1], in_if.cur_x});
      d1_q[1] <= $signed({in_if.goal_y[W-1], in_if.goal_y}) - $signed({in_if.cur_y[W-1], in_if.cur_y});
      d1_q[2] <= $signed({in_if.goal_z[W-1], in_if.goal_z}) - $signed({in_if.cur_z[W-1], in_if.cur_z});
      c1_q[0] <= in_if.cur_x;  c1_q[1] <= in_if.cur_y;  c1_q[2] <= in_if.cur_z;
      g1_q[0] <= in_if.goal_x; g1_q[1] <= in_if.goal_y; g1_q[2] <= in_if.goal_z;
      p1_q <= PW'(max_speed_q) * PW'(in_if.dt_us);
    end
  end

  // stage 2: magnitudes, signs, limit reciprocal partial products
  // floor(p / 1e6) = (p * 2^61/1e6 rounded up) >> 61 holds for p below 2^40
  localparam logic [41:0] RecipK  = 42'd2305843009214;
  localparam logic [20:0] RecipLo = RecipK[20:0];
  localparam logic [20:0] RecipHi = RecipK[41:21];
  logic          v2_q;
  logic [MW-1:0] m2_q [3];
  logic [2:0]    n2_q;
  logic [W-1:0]  c2_q [3];
  logic [W-1:0]  g2_q [3];
  logic [40:0]   pp2_q [4];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (en) v2_q <= v1_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        n2_q[i] <= d1_q[i][W];
        m2_q[i] <= d1_q[i][W] ? MW'(-d1_q[i]) : MW'(d1_q[i]);
      end
      c2_q <= c1_q;
      g2_q <= g1_q;
      pp2_q[0] <= 41'(p1_q[19:0]) * 41'(RecipLo);
      pp2_q[1] <= 41'(p1_q[19:0]) * 41'(RecipHi);
      pp2_q[2] <= 41'(p1_q[39:20]) * 41'(RecipLo);
      pp2_q[3] <= 41'(p1_q[39:20]) * 41'(RecipHi);
    end
  end

  // stage 3: squares and sum of the limit partial products
  logic            v3_q;
  logic [2*MW-1:0] s3_q [3];
  logic [81:0]     l3_q;
  logic [MW-1:0]   m3_q [3];
  logic [2:0]      n3_q;
  logic [W-1:0]    c3_q [3];
  logic [W-1:0]    g3_q [3];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else if (en) v3_q <= v2_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) s3_q[i] <= (2*MW)'(m2_q[i]) * (2*MW)'(m2_q[i]);
      l3_q <= 82'(pp2_q[0]) + (82'(pp2_q[1]) << 21) + (82'(pp2_q[2]) << 20) +
              (82'(pp2_q[3]) << 41);
      m3_q <= m2_q; n3_q <= n2_q; c3_q <= c2_q; g3_q <= g2_q;
    end
  end

  // stage 4: sum of squares, limit extract
  logic                  v4_q;
  logic [SW-1:0]         sum4_q;
  logic [TW-1:0]         tag4_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v4_q <= 1'b0;
    else if (en) v4_q <= v3_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      sum4_q <= SW'(s3_q[0]) + SW'(s3_q[1]) + SW'(s3_q[2]);
      tag4_q <= {m3_q[0], m3_q[1], m3_q[2], c3_q[0], c3_q[1], c3_q[2], n3_q,
                 l3_q[61 +: LimitWidth]};
    end
  end

  // square root pipeline
  logic          v5;
  logic [RW-1:0] dist5;
  logic [TW-1:0] tag5;
  slps_sqrt #(.RW(RW), .TW(TW)) u_sqrt (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v4_q), .rad_i((2*RW)'(sum4_q)),
    .tag_i(tag4_q), .valid_o(v5), .root_o(dist5), .tag_o(tag5)
  );

  // unpack tag after the root; the goal is not carried, it is rebuilt later from cur and mag
  logic [MW-1:0]         m5 [3];
  logic [W-1:0]          c5 [3];
  logic [2:0]            n5;
  logic [LimitWidth-1:0] lim5;
  assign {m5[0], m5[1], m5[2], c5[0], c5[1], c5[2], n5, lim5} = tag5;

  // stage 6: limit decision and numerators
  logic          v6_q;
  logic [NW-1:0] num6_q [3];
  logic [RW-1:0] den6_q;
  logic          lmt6_q;
  logic [W-1:0]  c6_q [3];
  logic [2:0]    n6_q;
  logic [MW-1:0] m6_q [3];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v6_q <= 1'b0;
    else if (en) v6_q <= v5;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) num6_q[i] <= NW'(m5[i]) * NW'(lim5);
      den6_q <= (dist5 == '0) ? RW'(1) : dist5;
      lmt6_q <= dist5 > RW'(lim5);
      c6_q <= c5; n6_q <= n5; m6_q <= m5;
    end
  end

  // three dividers in lanes
  localparam int unsigned DTW = 1 + 3 * W + 3 + 3 * MW;
  logic          v7 [3];
  logic [NW-1:0] q7 [3];
  logic [DTW-1:0] t7 [3];
  for (genvar i = 0; i < 3; i++) begin : g_div
    slps_div #(.NW(NW), .DW(RW), .TW(DTW)) u_div (
      .clk_i, .rst_ni, .en_i(en), .valid_i(v6_q), .num_i(num6_q[i]), .den_i(den6_q),
      .tag_i({lmt6_q, c6_q[0], c6_q[1], c6_q[2], n6_q, m6_q[0], m6_q[1], m6_q[2]}),
      .valid_o(v7[i]), .quo_o(q7[i]), .tag_o(t7[i])
    );
  end

  logic          lmt7;
  logic [W-1:0]  c7 [3];
  logic [2:0]    n7;
  logic [MW-1:0] m7 [3];
  assign {lmt7, c7[0], c7[1], c7[2], n7, m7[0], m7[1], m7[2]} = t7[0];

  // output register: apply offsets or take goal (cur +/- mag)
  logic [W-1:0] r [3];
  logic [W-1:0] goal [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      goal[i] = n7[i] ? c7[i] - W'(m7[i]) : c7[i] + W'(m7[i]);
      r[i]    = !lmt7 ? goal[i] :
                (n7[i] ? c7[i] - W'(q7[i]) : c7[i] + W'(q7[i]));
    end
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_if.valid <= 1'b0;
    else if (en) out_if.valid <= v7[0];
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      out_if.new_x   <= r[0];
      out_if.new_y   <= r[1];
      out_if.new_z   <= r[2];
      out_if.limited <= lmt7;
    end
  end

  // unused payload members of the shared channel type
  assign out_if.cur_x = '0;  assign out_if.cur_y = '0;  assign out_if.cur_z = '0;
  assign out_if.goal_x = '0; assign out_if.goal_y = '0; assign out_if.goal_z = '0;
  assign out_if.dt_us = '0;

  // lanes stay in step
  a_lanes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v7[0] == v7[1] && v7[0] == v7[2]) else $error("divider lanes out of step");
  // a stalled result stays valid and new_x holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.ready |=> out_if.valid && $stable(out_if.new_x))
    else $error("result changed under stall");
  // a limited step always has a nonzero distance to divide by
  a_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v6_q && lmt6_q |-> den6_q != '0)
    else $error("limit decision inconsistent");
endmodule
